[sv/ppmptg_pkg.sv]
// Shared types, constants and helper functions for the PPM pulse train generator.
package ppmptg_pkg;

  // Frame geometry
  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 12;
  localparam int TICK_W       = 16;
  localparam int IDX_W        = 3;
  localparam int VAL_W        = 16;
  localparam int SLOT_W       = $clog2(NUM_CHANNELS + 1);
  localparam int CMP_W        = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
  localparam int TOTAL_W      = CH_W + $clog2(NUM_CHANNELS);
  localparam int PAIRS        = (NUM_CHANNELS + 1) / 2;

  // Sync slot index (slot counter value after the last channel)
  localparam logic [SLOT_W-1:0] SYNC_SLOT = SLOT_W'(NUM_CHANNELS);

  // Cycles that derived frame values need to settle after a load or register write
  localparam int SETTLE_CYC = 4;
  localparam int SETTLE_W   = $clog2(SETTLE_CYC + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SYNC     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MIN  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAX  = CFG_IDX_W'(4);

  // Item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Reset values
  localparam logic [CH_W-1:0]   PULSE_WIDTH_RST  = CH_W'(300);
  localparam logic [TICK_W-1:0] FRAME_PERIOD_RST = TICK_W'(22500);
  localparam logic [TICK_W-1:0] MIN_SYNC_RST     = TICK_W'(3000);
  localparam logic [CH_W-1:0]   CHANNEL_MIN_RST  = CH_W'(1000);
  localparam logic [CH_W-1:0]   CHANNEL_MAX_RST  = CH_W'(2000);
  localparam logic [CH_W-1:0]   SHADOW_RST       = CH_W'(1000);
  localparam logic [CH_W-1:0]   CH_SAT           = {CH_W{1'b1}};

  // Input item
  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] channel_index;
    logic [VAL_W-1:0] channel_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic pin_level;
    logic frame_start;
  } out_item_t;

  // Registers that every slot cell sees
  typedef struct packed {
    logic [CH_W-1:0] pulse_width;
    logic [CH_W-1:0] channel_min;
    logic [CH_W-1:0] channel_max;
  } slot_cfg_t;

  // Phase search token handed from slot to slot
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              high;
    logic [CH_W-1:0]   len;
  } scan_t;

  // Sync gap: max(min_sync, frame_period - total), floored at zero
  function automatic logic [TICK_W-1:0] gap_len(input logic [TOTAL_W-1:0] total,
                                                input logic [TICK_W-1:0] period,
                                                input logic [TICK_W-1:0] min_gap);
    logic [TICK_W-1:0] tot;
    logic [TICK_W-1:0] gap;
    tot = TICK_W'(total);
    gap = (period > tot) ? (period - tot) : '0;
    return (gap > min_gap) ? gap : min_gap;
  endfunction

endpackage

[sv/ppmptg_cell.sv]
// One channel slot: shadow/active value, clamp, phase lengths and phase search stage.
module ppmptg_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ppmptg_pkg::SLOT_W-1:0] cell_idx,
  input  logic                       ld_en,
  input  logic [ppmptg_pkg::IDX_W-1:0]  ld_idx,
  input  logic [ppmptg_pkg::CH_W-1:0]   ld_val,
  input  ppmptg_pkg::slot_cfg_t      cfg,
  input  logic                       latch,
  input  logic [ppmptg_pkg::SLOT_W-1:0] cur_slot,
  input  logic                       cur_high,
  input  ppmptg_pkg::scan_t          old_in,
  input  ppmptg_pkg::scan_t          new_in,
  output ppmptg_pkg::scan_t          old_out,
  output ppmptg_pkg::scan_t          new_out,
  output logic [ppmptg_pkg::CH_W-1:0]   clamp_q
);

  logic [ppmptg_pkg::CH_W-1:0] shadow_r;
  logic [ppmptg_pkg::CH_W-1:0] clamp_r;
  logic [ppmptg_pkg::CH_W-1:0] active_r;
  logic                        act_nz_r;
  logic [ppmptg_pkg::CH_W-1:0] act_low_r;
  logic                        pend_nz_r;
  logic [ppmptg_pkg::CH_W-1:0] pend_low_r;
  logic [ppmptg_pkg::CH_W-1:0] clamp_nxt;
  logic                        ld_hit;
  logic                        hi_nz;
  logic                        after_cur;
  logic                        old_hi_ok;
  logic                        old_lo_ok;

  // Load address match; indexes at or past the channel count never match
  assign ld_hit = ld_en &&
                  (ppmptg_pkg::CMP_W'(ld_idx) == ppmptg_pkg::CMP_W'(cell_idx));

  // Clamp, lower bound tested first
  always_comb begin
    if (shadow_r < cfg.channel_min) begin
      clamp_nxt = cfg.channel_min;
    end else if (shadow_r > cfg.channel_max) begin
      clamp_nxt = cfg.channel_max;
    end else begin
      clamp_nxt = shadow_r;
    end
  end

  // Shadow value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r <= ppmptg_pkg::SHADOW_RST;
    end else if (ld_hit) begin
      shadow_r <= ld_val;
    end
  end

  // Derived per-slot values for the pending and the active frame
  always_ff @(posedge clk) begin
    clamp_r    <= clamp_nxt;
    pend_nz_r  <= (clamp_r > cfg.pulse_width);
    pend_low_r <= clamp_r - cfg.pulse_width;
    if (latch) begin
      active_r  <= clamp_r;
      act_nz_r  <= pend_nz_r;
      act_low_r <= pend_low_r;
    end else begin
      act_nz_r  <= (active_r > cfg.pulse_width);
      act_low_r <= active_r - cfg.pulse_width;
    end
  end

  assign clamp_q = clamp_r;

  // Phase search: first nonzero phase after the current one (active frame)
  assign hi_nz     = (cfg.pulse_width != '0);
  assign after_cur = (cell_idx > cur_slot);
  assign old_hi_ok = after_cur && hi_nz;
  assign old_lo_ok = (after_cur || ((cell_idx == cur_slot) && cur_high)) && act_nz_r;

  always_comb begin
    old_out = old_in;
    if (!old_in.hit) begin
      if (old_hi_ok) begin
        old_out = '{hit: 1'b1, slot: cell_idx, high: 1'b1, len: cfg.pulse_width};
      end else if (old_lo_ok) begin
        old_out = '{hit: 1'b1, slot: cell_idx, high: 1'b0, len: act_low_r};
      end
    end
  end

  // Phase search from the frame start (pending frame)
  always_comb begin
    new_out = new_in;
    if (!new_in.hit) begin
      if (hi_nz) begin
        new_out = '{hit: 1'b1, slot: cell_idx, high: 1'b1, len: cfg.pulse_width};
      end else if (pend_nz_r) begin
        new_out = '{hit: 1'b1, slot: cell_idx, high: 1'b0, len: pend_low_r};
      end
    end
  end

endmodule

[sv/ppm_pulse_train_generator.sv]
// An accepted item's result is in the output register in the cycle after it is accepted.
// One item per cycle unless the output is stalled by out_ready low; a tick waits after a
// load or register write while the clamped frame sum and sync gap registers settle.
// The phase search ripples through the row of slot cells within the tick's cycle.
// Reset (rst_n low, synchronous) puts the generator in the sync slot with zero
// ticks left, so the first tick starts a frame; ticks are held off until the settle counter runs out.
module ppm_pulse_train_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ppmptg_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ppmptg_pkg::out_item_t                out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppmptg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppmptg_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int N = ppmptg_pkg::NUM_CHANNELS;

  // Configuration registers
  logic [ppmptg_pkg::CH_W-1:0]   pw_r;
  logic [ppmptg_pkg::TICK_W-1:0] fp_r;
  logic [ppmptg_pkg::TICK_W-1:0] ms_r;
  logic [ppmptg_pkg::CH_W-1:0]   cmin_r;
  logic [ppmptg_pkg::CH_W-1:0]   cmax_r;

  // Frame state
  logic [ppmptg_pkg::SLOT_W-1:0] slot_r;
  logic                          high_r;
  logic [ppmptg_pkg::TICK_W-1:0] ticks_r;
  logic                          pin_r;
  logic [ppmptg_pkg::SETTLE_W-1:0] settle_r;

  // Frame sums and gaps
  logic [ppmptg_pkg::CH_W:0]      pair_r [ppmptg_pkg::PAIRS];
  logic [ppmptg_pkg::TOTAL_W-1:0] pre_total_r;
  logic [ppmptg_pkg::TOTAL_W-1:0] pre_total_nxt;
  logic [ppmptg_pkg::TOTAL_W-1:0] frame_total_r;
  logic [ppmptg_pkg::TICK_W-1:0]  new_gap_r;
  logic [ppmptg_pkg::TICK_W-1:0]  old_gap_r;

  // Output register
  logic                  out_valid_r;
  ppmptg_pkg::out_item_t out_data_r;

  // Handshake and per-tick decision
  logic                          out_free;
  logic                          in_fire;
  logic                          tick_fire;
  logic                          load_fire;
  logic                          cfg_fire;
  logic                          at_sync;
  logic                          latch;
  logic                          latch_en;
  logic [ppmptg_pkg::SLOT_W-1:0] slot_nxt;
  logic                          high_nxt;
  logic [ppmptg_pkg::TICK_W-1:0] len;
  logic [ppmptg_pkg::TICK_W-1:0] ticks_nxt;
  logic                          pin_nxt;
  logic [ppmptg_pkg::CH_W-1:0]   ld_val;
  ppmptg_pkg::slot_cfg_t         slot_cfg;
  ppmptg_pkg::scan_t             old_c [N+1];
  ppmptg_pkg::scan_t             new_c [N+1];
  logic [ppmptg_pkg::CH_W-1:0]   clamp_q [N];

  // Handshakes
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = out_free &&
                     ((settle_r == '0) || (in_data.mode == ppmptg_pkg::MODE_LOAD));
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && (in_data.mode == ppmptg_pkg::MODE_TICK);
  assign load_fire = in_fire && (in_data.mode == ppmptg_pkg::MODE_LOAD);
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r   <= ppmptg_pkg::PULSE_WIDTH_RST;
      fp_r   <= ppmptg_pkg::FRAME_PERIOD_RST;
      ms_r   <= ppmptg_pkg::MIN_SYNC_RST;
      cmin_r <= ppmptg_pkg::CHANNEL_MIN_RST;
      cmax_r <= ppmptg_pkg::CHANNEL_MAX_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        ppmptg_pkg::REG_PULSE_WIDTH:  pw_r   <= cfg_data[ppmptg_pkg::CH_W-1:0];
        ppmptg_pkg::REG_FRAME_PERIOD: fp_r   <= cfg_data;
        ppmptg_pkg::REG_MIN_SYNC:     ms_r   <= cfg_data;
        ppmptg_pkg::REG_CHANNEL_MIN:  cmin_r <= cfg_data[ppmptg_pkg::CH_W-1:0];
        ppmptg_pkg::REG_CHANNEL_MAX:  cmax_r <= cfg_data[ppmptg_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign slot_cfg = '{pulse_width: pw_r, channel_min: cmin_r, channel_max: cmax_r};

  // Load value saturates to the channel width
  assign ld_val = (in_data.channel_value > ppmptg_pkg::VAL_W'(ppmptg_pkg::CH_SAT)) ?
                  ppmptg_pkg::CH_SAT : in_data.channel_value[ppmptg_pkg::CH_W-1:0];

  // Row of slot cells; the search tokens enter at slot 0
  assign old_c[0] = '0;
  assign new_c[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_slot
    ppmptg_cell u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (ppmptg_pkg::SLOT_W'(i)),
      .ld_en    (load_fire),
      .ld_idx   (in_data.channel_index),
      .ld_val   (ld_val),
      .cfg      (slot_cfg),
      .latch    (latch_en),
      .cur_slot (slot_r),
      .cur_high (high_r),
      .old_in   (old_c[i]),
      .new_in   (new_c[i]),
      .old_out  (old_c[i+1]),
      .new_out  (new_c[i+1]),
      .clamp_q  (clamp_q[i])
    );
  end

  // Pair sums of the clamped shadow values
  for (genvar j = 0; j < ppmptg_pkg::PAIRS; j++) begin : g_pair
    if (2 * j + 1 < N) begin : g_two
      always_ff @(posedge clk) begin
        pair_r[j] <= {1'b0, clamp_q[2*j]} + {1'b0, clamp_q[2*j+1]};
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        pair_r[j] <= {1'b0, clamp_q[2*j]};
      end
    end
  end

  // Frame total of the pending set
  always_comb begin
    pre_total_nxt = '0;
    for (int k = 0; k < ppmptg_pkg::PAIRS; k++) begin
      pre_total_nxt = pre_total_nxt + ppmptg_pkg::TOTAL_W'(pair_r[k]);
    end
  end

  // Sync gaps for the pending and the active frame
  always_ff @(posedge clk) begin
    pre_total_r <= pre_total_nxt;
    new_gap_r   <= ppmptg_pkg::gap_len(pre_total_r, fp_r, ms_r);
    if (latch_en) begin
      frame_total_r <= pre_total_r;
      old_gap_r     <= new_gap_r;
    end else begin
      old_gap_r <= ppmptg_pkg::gap_len(frame_total_r, fp_r, ms_r);
    end
  end

  // Next phase: count down, or skip zero-length phases and start frames
  assign at_sync = (slot_r == ppmptg_pkg::SYNC_SLOT);

  always_comb begin
    latch    = 1'b0;
    slot_nxt = slot_r;
    high_nxt = high_r;
    len      = ticks_r;
    if (ticks_r == '0) begin
      priority if (!at_sync && old_c[N].hit) begin
        slot_nxt = old_c[N].slot;
        high_nxt = old_c[N].high;
        len      = ppmptg_pkg::TICK_W'(old_c[N].len);
      end else if (!at_sync && (old_gap_r != '0)) begin
        slot_nxt = ppmptg_pkg::SYNC_SLOT;
        high_nxt = 1'b0;
        len      = old_gap_r;
      end else if (new_c[N].hit) begin
        latch    = 1'b1;
        slot_nxt = new_c[N].slot;
        high_nxt = new_c[N].high;
        len      = ppmptg_pkg::TICK_W'(new_c[N].len);
      end else begin
        latch    = 1'b1;
        slot_nxt = ppmptg_pkg::SYNC_SLOT;
        high_nxt = 1'b0;
        len      = new_gap_r;
      end
    end
    ticks_nxt = (len == '0) ? '0 : len - 1'b1;
    pin_nxt   = high_nxt && (slot_nxt != ppmptg_pkg::SYNC_SLOT) && (len != '0);
  end

  assign latch_en = tick_fire && latch;

  // Frame state and settle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= ppmptg_pkg::SYNC_SLOT;
      high_r   <= 1'b0;
      ticks_r  <= '0;
      pin_r    <= 1'b0;
      settle_r <= ppmptg_pkg::SETTLE_W'(ppmptg_pkg::SETTLE_CYC);
    end else begin
      if (tick_fire) begin
        slot_r  <= slot_nxt;
        high_r  <= high_nxt;
        ticks_r <= ticks_nxt;
        pin_r   <= pin_nxt;
      end
      if (load_fire || cfg_fire) begin
        settle_r <= ppmptg_pkg::SETTLE_W'(ppmptg_pkg::SETTLE_CYC);
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 1'b1;
      end
    end
  end

  // Result register; a load repeats the pin level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_data.mode == ppmptg_pkg::MODE_LOAD) begin
        out_data_r <= '{pin_level: pin_r, frame_start: 1'b0};
      end else begin
        out_data_r <= '{pin_level: pin_nxt, frame_start: latch};
      end
    end
  end

endmodule
